// ===== hdl/rws_pkg.sv =====
package rws_pkg;

  localparam int SLOT_W      = 6;
  localparam int WEIGHT_W    = 32;
  localparam int FRAC_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int ACT_W       = 2;
  localparam int BETA_W      = 50;
  localparam int PROD_W      = WEIGHT_W + FRAC_W;
  localparam int DIV_CNT_W   = $clog2(BETA_W);
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd25;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_DRAW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SLOT_W-1:0]     slot;
    logic [WEIGHT_W-1:0]   weight;
    logic [SLOT_W-1:0]     rstart;
    logic [FRAC_W-1:0]     frac;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_CHK,
    ST_DIV,
    ST_DIV_END,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_EMIT
  } st_t;

endpackage

// ===== hdl/rws_ram.sv =====
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rws_front.sv =====
module rws_front #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rws_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [rws_pkg::ACT_W-1:0]        in_tuser,
  output logic                             cmd_valid,
  input  logic                             cmd_pop,
  output rws_pkg::cmd_t                    cmd
);

  rws_pkg::cmd_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  rws_pkg::cmd_t cmd_in;
  logic          keep;
  logic          push;
  logic          pop;
  logic          slot_ok;

  always_comb begin
    cmd_in.slot   = in_tdata[5:0];
    cmd_in.weight = in_tdata[37:6];
    cmd_in.rstart = in_tdata[43:38];
    cmd_in.frac   = in_tdata[59:44];
    cmd_in.kind   = rws_pkg::CMD_LOAD;
    slot_ok       = int'(in_tdata[5:0]) < MAX_PARTICLES;
    keep          = 1'b0;
    case (in_tuser)
      rws_pkg::ACT_LOAD: begin
        cmd_in.kind = rws_pkg::CMD_LOAD;
        keep        = slot_ok;
      end
      rws_pkg::ACT_START: begin
        cmd_in.kind = rws_pkg::CMD_START;
        keep        = 1'b1;
      end
      rws_pkg::ACT_DRAW: begin
        cmd_in.kind = rws_pkg::CMD_DRAW;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hdl/rws_back.sv =====
module rws_back #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  output logic                                  cmd_pop,
  input  rws_pkg::cmd_t                         cmd,
  input  logic                                  cfg_we,
  input  logic [rws_pkg::COUNT_W-1:0]           cfg_wdata,
  output logic                                  ram_we,
  output logic [$clog2(MAX_PARTICLES)-1:0]      ram_waddr,
  output logic [rws_pkg::WEIGHT_W-1:0]          ram_wdata,
  output logic [$clog2(MAX_PARTICLES)-1:0]      ram_raddr,
  input  logic [rws_pkg::WEIGHT_W-1:0]          ram_rdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rws_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast
);

  localparam int IW  = $clog2(MAX_PARTICLES);
  localparam int NW  = $clog2(MAX_PARTICLES + 1);
  localparam int CW  = (NW > rws_pkg::COUNT_W) ? NW : rws_pkg::COUNT_W;
  localparam int TW  = rws_pkg::WEIGHT_W + IW;
  localparam int AW  = (TW + rws_pkg::FRAC_W > rws_pkg::BETA_W) ?
                       TW + rws_pkg::FRAC_W : rws_pkg::BETA_W;
  localparam int AW1 = AW + 1;
  localparam int BW  = rws_pkg::BETA_W;
  localparam int PW  = rws_pkg::PROD_W;

  rws_pkg::st_t                  state_r, state_nxt;
  logic [rws_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [rws_pkg::WEIGHT_W-1:0]  largest_r, largest_nxt;
  logic [BW-1:0]                 beta_r, beta_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [rws_pkg::COUNT_W-1:0]   draws_r, draws_nxt;
  logic                          total_valid_r, total_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          pend_r, pend_nxt;

  logic [TW-1:0]                 total_r, total_nxt;
  logic [TW-1:0]                 sum_r, sum_nxt;
  logic [rws_pkg::WEIGHT_W-1:0]  max_r, max_nxt;
  logic [CW-1:0]                 k_r, k_nxt;
  logic                          is_start_r, is_start_nxt;
  logic [rws_pkg::SLOT_W-1:0]    rs_r, rs_nxt;
  logic [rws_pkg::FRAC_W-1:0]    frac_r, frac_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [AW-1:0]                 rem_r, rem_nxt;
  logic [BW-1:0]                 divq_r, divq_nxt;
  logic [rws_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [rws_pkg::SLOT_W-1:0]    out_idx_r, out_idx_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CW-1:0]                 cnt_ext;
  logic [CW-1:0]                 max_c;
  logic [CW-1:0]                 n_eff;
  logic [AW-1:0]                 tot_sh;
  logic [AW1-1:0]                rem_t;
  logic [AW1-1:0]                tot_ext;
  logic [PW-1:0]                 w_sh;
  logic [CW-1:0]                 idx_p1;
  logic [IW-1:0]                 idx_wrap;
  logic [rws_pkg::COUNT_W-1:0]   draws_p1;
  logic                          done_flag;
  logic                          out_free;

  always_comb begin
    cnt_ext  = CW'(count_r);
    max_c    = CW'(MAX_PARTICLES);
    if (count_r == '0) begin
      n_eff = CW'(1);
    end else if (cnt_ext > max_c) begin
      n_eff = max_c;
    end else begin
      n_eff = cnt_ext;
    end
    tot_sh    = AW'({total_r, {rws_pkg::FRAC_W{1'b0}}});
    tot_ext   = AW1'(tot_sh);
    rem_t     = {rem_r, divq_r[BW-1]};
    w_sh      = {ram_rdata, {rws_pkg::FRAC_W{1'b0}}};
    idx_p1    = CW'(idx_r) + CW'(1);
    idx_wrap  = (idx_p1 >= n_eff) ? '0 : IW'(idx_p1);
    draws_p1  = draws_r + 7'd1;
    done_flag = CW'(draws_p1) >= n_eff;
    out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    largest_nxt     = largest_r;
    beta_nxt        = beta_r;
    idx_nxt         = idx_r;
    draws_nxt       = draws_r;
    total_valid_nxt = total_valid_r;
    out_valid_nxt   = out_valid_r;
    pend_nxt        = pend_r;
    total_nxt       = total_r;
    sum_nxt         = sum_r;
    max_nxt         = max_r;
    k_nxt           = k_r;
    is_start_nxt    = is_start_r;
    rs_nxt          = rs_r;
    frac_nxt        = frac_r;
    prod_nxt        = prod_r;
    rem_nxt         = rem_r;
    divq_nxt        = divq_r;
    div_cnt_nxt     = div_cnt_r;
    out_idx_nxt     = out_idx_r;
    out_last_nxt    = out_last_r;
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    ram_raddr       = idx_r;

    if (cfg_we) begin
      count_nxt       = cfg_wdata;
      total_valid_nxt = 1'b0;
    end
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rws_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            rws_pkg::CMD_LOAD: begin
              ram_we          = 1'b1;
              total_valid_nxt = 1'b0;
            end
            rws_pkg::CMD_START: begin
              is_start_nxt = 1'b1;
              rs_nxt       = cmd.rstart;
              k_nxt        = '0;
              pend_nxt     = 1'b0;
              sum_nxt      = '0;
              max_nxt      = '0;
              state_nxt    = rws_pkg::ST_SCAN;
            end
            rws_pkg::CMD_DRAW: begin
              is_start_nxt = 1'b0;
              frac_nxt     = cmd.frac;
              if (CW'(idx_r) >= n_eff) begin
                idx_nxt = IW'(n_eff - CW'(1));
              end
              if (total_valid_r) begin
                state_nxt = rws_pkg::ST_MUL;
              end else begin
                k_nxt     = '0;
                pend_nxt  = 1'b0;
                sum_nxt   = '0;
                max_nxt   = '0;
                state_nxt = rws_pkg::ST_SCAN;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      rws_pkg::ST_SCAN: begin
        ram_raddr = k_r[IW-1:0];
        if (pend_r) begin
          sum_nxt = sum_r + TW'(ram_rdata);
          if (ram_rdata > max_r) begin
            max_nxt = ram_rdata;
          end
        end
        if (k_r < n_eff) begin
          k_nxt    = k_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            total_nxt       = sum_r;
            total_valid_nxt = 1'b1;
            if (is_start_r) begin
              largest_nxt = max_r;
              beta_nxt    = '0;
              draws_nxt   = '0;
              if (CW'(rs_r) > n_eff - CW'(1)) begin
                idx_nxt = IW'(n_eff - CW'(1));
              end else begin
                idx_nxt = IW'(rs_r);
              end
              state_nxt = rws_pkg::ST_IDLE;
            end else begin
              state_nxt = rws_pkg::ST_MUL;
            end
          end
        end
      end
      rws_pkg::ST_MUL: begin
        prod_nxt  = PW'(largest_r) * PW'(frac_r);
        state_nxt = rws_pkg::ST_ADD;
      end
      rws_pkg::ST_ADD: begin
        beta_nxt  = beta_r + BW'({prod_r, 1'b0});
        state_nxt = rws_pkg::ST_CHK;
      end
      rws_pkg::ST_CHK: begin
        if (total_r == '0) begin
          beta_nxt  = '0;
          state_nxt = rws_pkg::ST_EMIT;
        end else if (AW'(beta_r) > tot_sh) begin
          divq_nxt    = beta_r - BW'(1);
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = rws_pkg::ST_DIV;
        end else begin
          state_nxt = rws_pkg::ST_WALK_RD;
        end
      end
      rws_pkg::ST_DIV: begin
        if (rem_t >= tot_ext) begin
          rem_nxt = AW'(rem_t - tot_ext);
        end else begin
          rem_nxt = AW'(rem_t);
        end
        divq_nxt    = divq_r << 1;
        div_cnt_nxt = div_cnt_r + rws_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == rws_pkg::DIV_CNT_W'(BW - 1)) begin
          state_nxt = rws_pkg::ST_DIV_END;
        end
      end
      rws_pkg::ST_DIV_END: begin
        beta_nxt  = BW'(rem_r + AW'(1));
        state_nxt = rws_pkg::ST_WALK_RD;
      end
      rws_pkg::ST_WALK_RD: begin
        ram_raddr = idx_r;
        state_nxt = rws_pkg::ST_WALK_CMP;
      end
      rws_pkg::ST_WALK_CMP: begin
        if (beta_r > BW'(w_sh)) begin
          beta_nxt  = beta_r - BW'(w_sh);
          idx_nxt   = idx_wrap;
          state_nxt = rws_pkg::ST_WALK_RD;
        end else begin
          state_nxt = rws_pkg::ST_EMIT;
        end
      end
      rws_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = rws_pkg::SLOT_W'(idx_r);
          out_last_nxt  = done_flag;
          draws_nxt     = done_flag ? '0 : draws_p1;
          state_nxt     = rws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rws_pkg::ST_IDLE;
      count_r       <= rws_pkg::COUNT_RESET;
      largest_r     <= '0;
      beta_r        <= '0;
      idx_r         <= '0;
      draws_r       <= '0;
      total_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      largest_r     <= largest_nxt;
      beta_r        <= beta_nxt;
      idx_r         <= idx_nxt;
      draws_r       <= draws_nxt;
      total_valid_r <= total_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_r        <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    sum_r      <= sum_nxt;
    max_r      <= max_nxt;
    k_r        <= k_nxt;
    is_start_r <= is_start_nxt;
    rs_r       <= rs_nxt;
    frac_r     <= frac_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    divq_r     <= divq_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign ram_waddr  = IW'(cmd.slot);
  assign ram_wdata  = cmd.weight;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = rws_pkg::OUT_DATA_W'(out_idx_r);
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_walk_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_WALK_RD) |-> (total_valid_r && (total_r != '0)))
    else $error("wheel walk started without a nonzero weight total");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_WALK_RD) |-> (CW'(idx_r) < n_eff))
    else $error("wheel index outside the particles in use");

  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_DIV_END) |=> (AW'(beta_r) <= tot_sh))
    else $error("lap removal left beta above the weight total");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_SCAN) |-> (k_r <= n_eff))
    else $error("weight scan ran past the particles in use");
`endif

endmodule

// ===== hdl/resampling_wheel_selector.sv =====
// Resampling wheel selector for a particle filter. Input words carry a kind in
// in_tuser: load a weight into a slot, start a round, or draw one particle.
// Loads and starts give no output word; each draw gives one output word with
// the chosen slot, and out_tlast marks the draw that completes a round.
// The count of particles in use is written through cfg_we and cfg_wdata.
// A front stage decodes words into a two-entry command queue; the back stage
// executes commands against a single weight memory, one access per cycle.
// A load writes one weight in the back stage, and a start scans the weights in
// use for their sum and largest weight. A draw steps slot by slot around the
// wheel, skipping the walk when the weights in use sum to zero; it first
// rescans when weights or the count changed since the last scan, and the
// remainder unit removes whole laps when beta exceeds the weight total. When
// idle, the back stage starts a command the cycle after the queue takes it.
// Reset restores a count of 25 and clears the wheel state; weights stay
// undefined until loaded. When the receiver stalls, the result waits in the
// output register and the next draw holds before emitting; once the queue
// fills behind it, in_tready drops.
module resampling_wheel_selector #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot[5:0], weight[37:6], random_start[43:38], random_fraction[59:44]
  input  logic [rws_pkg::IN_DATA_W-1:0]   in_tdata,
  // action[1:0]
  input  logic [rws_pkg::ACT_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // selected_index[5:0]
  output logic [rws_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [rws_pkg::COUNT_W-1:0]     cfg_wdata
);

  localparam int IW = $clog2(MAX_PARTICLES);

  logic                          cmd_valid;
  logic                          cmd_pop;
  rws_pkg::cmd_t                 cmd;
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [rws_pkg::WEIGHT_W-1:0]  ram_wdata;
  logic [IW-1:0]                 ram_raddr;
  logic [rws_pkg::WEIGHT_W-1:0]  ram_rdata;

  rws_front #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  rws_ram #(
    .WIDTH (rws_pkg::WEIGHT_W),
    .DEPTH (MAX_PARTICLES)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rws_back #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
